// File: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// types and constants shared by the sorted priority queue core and its cells
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned PrioW   = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned OccW    = 5;

  // action codes
  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  // status codes
  localparam logic [StatusW-1:0] StInserted  = 2'd0;
  localparam logic [StatusW-1:0] StRemoved   = 2'd1;
  localparam logic [StatusW-1:0] StUnderflow = 2'd2;
  localparam logic [StatusW-1:0] StOverflow  = 2'd3;

  typedef struct packed {
    logic                     action;
    logic signed [ValueW-1:0] item_value;
    logic [PrioW-1:0]         item_priority;
  } spq_in_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] removed_value;
    logic [PrioW-1:0]         removed_priority;
    logic [OccW-1:0]          occupancy;
  } spq_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } spq_cmd_t;

endpackage

// File: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// one slot of the sorted chain: holds an entry, shifts right on insert,
// shifts left on remove
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
  parameter int unsigned PRIO_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spq_cmd_t          cmd_i,
  input  logic [ValueW-1:0] new_value_i,
  input  logic [PRIO_W-1:0] new_prio_i,
  // left neighbor (closer to the head)
  input  logic              left_valid_i,
  input  logic [ValueW-1:0] left_value_i,
  input  logic [PRIO_W-1:0] left_prio_i,
  input  logic              left_gt_i,
  // right neighbor (closer to the tail)
  input  logic              right_valid_i,
  input  logic [ValueW-1:0] right_value_i,
  input  logic [PRIO_W-1:0] right_prio_i,
  // own contents
  output logic              valid_o,
  output logic [ValueW-1:0] value_o,
  output logic [PRIO_W-1:0] prio_o,
  output logic              gt_o
);

  logic              valid_d, valid_q;
  logic [ValueW-1:0] value_d, value_q;
  logic [PRIO_W-1:0] prio_d, prio_q;

  // empty slot counts as greater than anything
  assign gt_o = !valid_q || (prio_q > new_prio_i);

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    prio_d  = prio_q;
    if (cmd_i.ins) begin
      if (left_gt_i) begin
        valid_d = left_valid_i;
        value_d = left_value_i;
        prio_d  = left_prio_i;
      end else if (gt_o) begin
        valid_d = 1'b1;
        value_d = new_value_i;
        prio_d  = new_prio_i;
      end
    end else if (cmd_i.rem) begin
      valid_d = right_valid_i;
      value_d = right_value_i;
      prio_d  = right_prio_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    prio_q  <= prio_d;
  end

  assign valid_o = valid_q;
  assign value_o = value_q;
  assign prio_o  = prio_q;

endmodule

// File: hw/rtl/sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_core
// bounded min-first priority queue built as a systolic chain of sorted cells
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its input transaction is accepted
// throughput: one transaction per cycle unless a waiting result stalls input, set by the cell shift
//   (every cell compares against the broadcast priority, and cells move at most one slot)
// a waiting result stalls input only while out_ready_i is low
// reset: asynchronous, clears every cell valid bit, the count and the output valid flag
module sorted_priority_queue_core import spq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH   = 16,
  parameter int unsigned PRIORITY_BITS = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  spq_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output spq_out_t out_data_o
);

  // stored priority width: input field is only PrioW bits wide
  localparam int unsigned StoreW = (PRIORITY_BITS < PrioW) ? PRIORITY_BITS : PrioW;
  localparam int unsigned CntW   = $clog2(QUEUE_DEPTH + 1);

  logic              accept;
  logic              full, empty;
  spq_cmd_t          cmd;
  logic [StoreW-1:0] new_prio;

  // chain wiring, one element per cell
  logic              cell_valid [QUEUE_DEPTH];
  logic [ValueW-1:0] cell_value [QUEUE_DEPTH];
  logic [StoreW-1:0] cell_prio  [QUEUE_DEPTH];
  logic              cell_gt    [QUEUE_DEPTH];

  logic [CntW-1:0]   count_d, count_q;
  logic              out_valid_d, out_valid_q;
  spq_out_t          out_d, out_q;

  // output register frees up in the same cycle it is taken
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty = (count_q == '0);

  // priority masked to its configured width
  assign new_prio = in_data_i.item_priority[StoreW-1:0];

  // commands only fire when they change the contents
  assign cmd.ins = accept && (in_data_i.action == ActInsert) && !full;
  assign cmd.rem = accept && (in_data_i.action == ActRemove) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic              left_valid, left_gt, right_valid;
    logic [ValueW-1:0] left_value, right_value;
    logic [StoreW-1:0] left_prio, right_prio;

    if (g == 0) begin : g_head
      // nothing to the left of the head: new entry always fits here if greater
      assign left_valid = 1'b0;
      assign left_value = '0;
      assign left_prio  = '0;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_valid = cell_valid[g-1];
      assign left_value = cell_value[g-1];
      assign left_prio  = cell_prio[g-1];
      assign left_gt    = cell_gt[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      // vacated tail slot is cleared to zero
      assign right_valid = 1'b0;
      assign right_value = '0;
      assign right_prio  = '0;
    end else begin : g_body
      assign right_valid = cell_valid[g+1];
      assign right_value = cell_value[g+1];
      assign right_prio  = cell_prio[g+1];
    end

    spq_cell #(
      .PRIO_W (StoreW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .cmd_i         (cmd),
      .new_value_i   (in_data_i.item_value),
      .new_prio_i    (new_prio),
      .left_valid_i  (left_valid),
      .left_value_i  (left_value),
      .left_prio_i   (left_prio),
      .left_gt_i     (left_gt),
      .right_valid_i (right_valid),
      .right_value_i (right_value),
      .right_prio_i  (right_prio),
      .valid_o       (cell_valid[g]),
      .value_o       (cell_value[g]),
      .prio_o        (cell_prio[g]),
      .gt_o          (cell_gt[g])
    );
  end

  // entry count and result for the accepted transaction
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      out_valid_d            = 1'b1;
      out_d.removed_value    = '0;
      out_d.removed_priority = '0;
      if (in_data_i.action == ActInsert) begin
        if (full) begin
          out_d.status = StOverflow;
        end else begin
          out_d.status = StInserted;
          count_d      = count_q + CntW'(1);
        end
      end else begin
        if (empty) begin
          out_d.status = StUnderflow;
        end else begin
          // head cell holds the smallest, oldest entry
          out_d.status           = StRemoved;
          out_d.removed_value    = cell_value[0];
          out_d.removed_priority = PrioW'(cell_prio[0]);
          count_d                = count_q - CntW'(1);
        end
      end
      out_d.occupancy = OccW'(count_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: test/tb_sorted_priority_queue_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_priority_queue_core
// self-checking bench for the min-first sorted priority queue core
// ----------------------------------------------------------------------------
// a scoreboard class keeps its own sorted copy of the queue and predicts the
// status, removed entry and occupancy of every accepted input transaction;
// each output transaction is checked field by field against the oldest
// prediction. a short directed run covers the empty remove, full insert,
// extreme values and equal-priority ordering, then random segments that lean
// toward filling or draining the queue follow. the sender idles in bursts,
// the receiver stalls on its own pattern, and a watchdog ends a hung run.
// ----------------------------------------------------------------------------
module tb_sorted_priority_queue_core;
  import spq_pkg::*;

  localparam int unsigned TbDepth     = 16;
  localparam int unsigned TbPrioBits  = 8;
  localparam int unsigned RandomItems = 1950;
  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned TailCycles  = 16;

  typedef enum logic [1:0] { SegFill, SegDrain, SegMixed } seg_kind_e;
  typedef enum logic [1:0] { RdyFree, RdyPattern, RdyRandom } rdy_kind_e;

  // --------------------------------------------------------------------------
  // scoreboard: sorted mirror of the queue plus the predicted outcomes
  // --------------------------------------------------------------------------
  class spq_scoreboard;
    logic signed [ValueW-1:0] mirror_value [TbDepth];
    logic [PrioW-1:0]         mirror_prio  [TbDepth];
    int unsigned              mirror_count;
    spq_out_t                 outcome_q [$];
    int unsigned              mismatches;

    function new();
      foreach (mirror_value[i]) begin
        mirror_value[i] = '0;
        mirror_prio[i]  = '0;
      end
      mirror_count = 0;
      mismatches   = 0;
    endfunction

    // one queue operation on the mirror, returns the outcome it causes
    function spq_out_t apply_queue_op(spq_in_t d);
      spq_out_t         res;
      logic [PrioW-1:0] pri;
      int unsigned      pos;
      res = '0;
      pri = d.item_priority & PrioW'((64'd1 << TbPrioBits) - 1);
      if (d.action == ActInsert) begin
        if (mirror_count >= TbDepth) begin
          res.status = StOverflow;
        end else begin
          // new entry goes behind every entry of equal or smaller priority
          pos = 0;
          while (pos < mirror_count && mirror_prio[pos] <= pri) pos++;
          for (int unsigned i = mirror_count; i > pos; i--) begin
            mirror_value[i] = mirror_value[i-1];
            mirror_prio[i]  = mirror_prio[i-1];
          end
          mirror_value[pos] = d.item_value;
          mirror_prio[pos]  = pri;
          mirror_count++;
          res.status = StInserted;
        end
      end else begin
        if (mirror_count == 0) begin
          res.status = StUnderflow;
        end else begin
          res.status           = StRemoved;
          res.removed_value    = mirror_value[0];
          res.removed_priority = mirror_prio[0];
          for (int unsigned i = 1; i < mirror_count; i++) begin
            mirror_value[i-1] = mirror_value[i];
            mirror_prio[i-1]  = mirror_prio[i];
          end
          mirror_count--;
          mirror_value[mirror_count] = '0;
          mirror_prio[mirror_count]  = '0;
        end
      end
      res.occupancy = OccW'(mirror_count);
      return res;
    endfunction

    function void note_input(spq_in_t d);
      outcome_q.push_back(apply_queue_op(d));
    endfunction

    function void check_result(spq_out_t got);
      spq_out_t want;
      if (outcome_q.size() == 0) begin
        $error("unexpected output transaction: status %0d value %0d prio %0d occ %0d",
               got.status, got.removed_value, got.removed_priority, got.occupancy);
        mismatches++;
        return;
      end
      want = outcome_q.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        mismatches++;
      end
      if (got.removed_value !== want.removed_value) begin
        $error("removed_value: expected %0d, actual %0d",
               want.removed_value, got.removed_value);
        mismatches++;
      end
      if (got.removed_priority !== want.removed_priority) begin
        $error("removed_priority: expected %0d, actual %0d",
               want.removed_priority, got.removed_priority);
        mismatches++;
      end
      if (got.occupancy !== want.occupancy) begin
        $error("occupancy: expected %0d, actual %0d", want.occupancy, got.occupancy);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // dut signals, inputs driven to known values from time zero
  // --------------------------------------------------------------------------
  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_ready_o;
  spq_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_ready_i = 1'b0;
  spq_out_t out_data_o;

  spq_scoreboard sb = new();

  // sender burst bookkeeping
  int unsigned burst_left = 0;

  // directed fill: extreme values, priorities at both ends, several ties
  logic [ValueW-1:0] dir_value [TbDepth] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
    32'h0000_0001, 32'h5555_5555, 32'haaaa_aaaa, 32'h0000_007b,
    32'hffff_fffe, 32'h1234_5678, 32'h8765_4321, 32'h0f0f_0f0f,
    32'hf0f0_f0f0, 32'h0000_0002, 32'h0000_0003, 32'h7fff_fffe
  };
  logic [PrioW-1:0] dir_prio [TbDepth] = '{
    8'hff, 8'h00, 8'h00, 8'h80, 8'h00, 8'hff, 8'h80, 8'h01,
    8'hfe, 8'h00, 8'hff, 8'h80, 8'h07, 8'h00, 8'hff, 8'h01
  };

  sorted_priority_queue_core #(
    .QUEUE_DEPTH   (TbDepth),
    .PRIORITY_BITS (TbPrioBits)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // 10 ns clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // monitor: every signal changes by nonblocking assignment at the edge, so
  // the values read here are the ones the dut saw at this edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
    end
  end

  // watchdog: cycles in a row with no transaction on either channel
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // receiver: stall behavior switches between free flow, a rotating bit
  // pattern and coin flips, each for a random stretch of cycles
  // --------------------------------------------------------------------------
  rdy_kind_e   rdy_kind    = RdyFree;
  int unsigned rdy_run     = 0;
  logic [7:0]  rdy_pattern = 8'hff;

  always @(posedge clk_i) begin
    if (rdy_run == 0) begin
      rdy_kind    <= rdy_kind_e'($urandom_range(0, 2));
      rdy_run     <= $urandom_range(32, 200);
      rdy_pattern <= 8'($urandom) | 8'h01;  // keep at least one ready slot
    end else begin
      rdy_run     <= rdy_run - 1;
      rdy_pattern <= {rdy_pattern[6:0], rdy_pattern[7]};
    end
    case (rdy_kind)
      RdyFree:    out_ready_i <= 1'b1;
      RdyPattern: out_ready_i <= rdy_pattern[7];
      default:    out_ready_i <= 1'($urandom_range(0, 1));
    endcase
  end

  // --------------------------------------------------------------------------
  // sender tasks, always entered right after a rising edge
  // --------------------------------------------------------------------------
  function automatic spq_in_t make_item(logic act, logic [ValueW-1:0] v,
                                        logic [PrioW-1:0] p);
    spq_in_t d;
    d.action        = act;
    d.item_value    = v;
    d.item_priority = p;
    return d;
  endfunction

  // hold valid and payload until the transaction is taken
  task automatic send_item(input spq_in_t d);
    in_valid_i <= 1'b1;
    in_data_i  <= d;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // one transaction, then a gap whenever the current burst runs out
  task automatic drive_item(input spq_in_t d);
    int unsigned gap;
    send_item(d);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 4);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // drop valid and hold off until every predicted outcome has been seen
  task automatic wait_for_drain();
    if (in_valid_i) in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin
    int unsigned      sent;
    int unsigned      seg_len;
    seg_kind_e        seg_kind;
    logic             narrow;
    logic [PrioW-1:0] base;
    logic             act;
    logic [PrioW-1:0] pri;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // remove on an empty queue, payload must not matter
    drive_item(make_item(ActRemove, 32'h7fff_ffff, 8'hff));
    // fill to the brim with extremes and ties
    for (int i = 0; i < TbDepth; i++) begin
      drive_item(make_item(ActInsert, dir_value[i], dir_prio[i]));
    end
    // insert into a full queue is dropped
    drive_item(make_item(ActInsert, 32'h8000_0000, 8'h00));
    // pull a few heads, ties should leave in arrival order
    repeat (6) drive_item(make_item(ActRemove, 32'hffff_ffff, 8'h00));

    // sender waits until the queue has answered everything
    wait_for_drain();

    // random segments leaning toward fill, drain or a mix
    sent = 0;
    while (sent < RandomItems) begin
      seg_len  = $urandom_range(20, 120);
      seg_kind = seg_kind_e'($urandom_range(0, 2));
      narrow   = 1'($urandom_range(0, 1));
      base     = 8'($urandom);
      for (int k = 0; k < seg_len && sent < RandomItems; k++) begin
        case (seg_kind)
          SegFill:  act = ($urandom_range(0, 99) < 85) ? ActInsert : ActRemove;
          SegDrain: act = ($urandom_range(0, 99) < 85) ? ActRemove : ActInsert;
          default:  act = ($urandom_range(0, 1) == 0) ? ActInsert : ActRemove;
        endcase
        // a narrow priority band makes ties common
        pri = narrow ? 8'(base + $urandom_range(0, 3)) : 8'($urandom);
        drive_item(make_item(act, 32'($urandom), pri));
        sent++;
      end
      if ($urandom_range(0, 5) == 0) wait_for_drain();
    end

    // let the last outcomes arrive, then a few quiet cycles
    wait_for_drain();
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $error("%0d predicted outcomes never arrived", sb.pending());
      sb.mismatches++;
    end

    if (sb.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
